// File: rtl/core/bounded_stack_remove_middle_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack core
// Shared wrappers for concurrent assertions on a clock with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_REMOVE_MIDDLE_CORE_ASSERT_SVH
`define BOUNDED_STACK_REMOVE_MIDDLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSRM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/bsrm_pkg.sv
// ----------------------------------------------------------------------------
// Bounded stack package
// Field widths, command and status codes, controller states and the
// command and status structures between controller and datapath.
// ----------------------------------------------------------------------------
package bsrm_pkg;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned OFFSET_W = 3;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 4;

   // Command codes of an input item.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_NO_MIDDLE = 3'd3,
      STATUS_RANGE     = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   // Source of the memory read address.
   typedef enum logic [1:0] {
      RD_TOP,
      RD_OFFSET,
      RD_MID,
      RD_NEXT
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch_req;
      logic       push_wr;
      logic       shift_wr;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       ptr_load;
      logic       count_inc;
      logic       count_dec;
      logic       res_load;
      status_type res_status;
      logic       res_from_mem;
      logic       rsp_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    one;
      logic    offset_bad;
      logic    shift_last;
   } dp_flags_type;

endpackage

// File: rtl/core/bsrm_req_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one stack command per transfer.
// ----------------------------------------------------------------------------
interface bsrm_req_if;

   logic                                valid;
   logic                                ready;
   logic [bsrm_pkg::CMD_W-1:0]          cmd;
   logic signed [bsrm_pkg::DATA_W-1:0]  push_value;
   logic [bsrm_pkg::OFFSET_W-1:0]       read_offset;

   modport source (output valid, output cmd, output push_value, output read_offset,
                   input ready);
   modport sink (input valid, input cmd, input push_value, input read_offset,
                 output ready);
   modport monitor (input valid, input ready, input cmd, input push_value,
                    input read_offset);

endinterface

// File: rtl/core/bsrm_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one command result per transfer.
// ----------------------------------------------------------------------------
interface bsrm_rsp_if;

   logic                                valid;
   logic                                ready;
   logic [bsrm_pkg::STATUS_W-1:0]       status;
   logic signed [bsrm_pkg::DATA_W-1:0]  read_data;
   logic [bsrm_pkg::COUNT_W-1:0]        entry_count;

   modport source (output valid, output status, output read_data, output entry_count,
                   input ready);
   modport sink (input valid, input status, input read_data, input entry_count,
                 output ready);
   modport monitor (input valid, input ready, input status, input read_data,
                    input entry_count);

endinterface

// File: rtl/core/bsrm_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded stack controller
// Sequences one command at a time: checks, memory reads, the shift loop of
// remove-middle and the hand-off into the result register.
// ----------------------------------------------------------------------------
module bsrm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bsrm_pkg::dp_flags_type  flags,
   output bsrm_pkg::ctrl_cmd_type  cmd
);

   bsrm_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsrm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      cmd              = '0;
      cmd.rd_sel       = bsrm_pkg::RD_TOP;
      cmd.res_status   = bsrm_pkg::STATUS_OK;

      case (state_ff)
         bsrm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = bsrm_pkg::S_EXEC;
            end
         end
         bsrm_pkg::S_EXEC: begin
            // Refused commands finish here with a zero data word.
            state_in = bsrm_pkg::S_FINISH;
            case (flags.cmd)
               bsrm_pkg::CMD_PUSH: begin
                  cmd.res_load = 1'b1;
                  if (flags.full) begin
                     cmd.res_status = bsrm_pkg::STATUS_FULL;
                  end else begin
                     cmd.push_wr   = 1'b1;
                     cmd.count_inc = 1'b1;
                  end
               end
               bsrm_pkg::CMD_POP: begin
                  if (flags.empty) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = bsrm_pkg::STATUS_EMPTY;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = bsrm_pkg::RD_TOP;
                     state_in   = bsrm_pkg::S_READ;
                  end
               end
               bsrm_pkg::CMD_REMOVE: begin
                  if (flags.empty) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = bsrm_pkg::STATUS_EMPTY;
                  end else if (flags.one) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = bsrm_pkg::STATUS_NO_MIDDLE;
                  end else begin
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = bsrm_pkg::RD_MID;
                     cmd.ptr_load = 1'b1;
                     state_in     = bsrm_pkg::S_READ;
                  end
               end
               bsrm_pkg::CMD_READ: begin
                  if (flags.empty) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = bsrm_pkg::STATUS_EMPTY;
                  end else if (flags.offset_bad) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = bsrm_pkg::STATUS_RANGE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = bsrm_pkg::RD_OFFSET;
                     state_in   = bsrm_pkg::S_READ;
                  end
               end
               default: begin
                  state_in = bsrm_pkg::S_IDLE;
               end
            endcase
         end
         bsrm_pkg::S_READ: begin
            // The word read is the result data of pop, read and remove-middle.
            cmd.res_load     = 1'b1;
            cmd.res_from_mem = 1'b1;
            state_in         = bsrm_pkg::S_FINISH;
            if (flags.cmd == bsrm_pkg::CMD_POP) begin
               cmd.count_dec = 1'b1;
            end else if (flags.cmd == bsrm_pkg::CMD_REMOVE) begin
               state_in = bsrm_pkg::S_SHIFT_RD;
            end
         end
         bsrm_pkg::S_SHIFT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bsrm_pkg::RD_NEXT;
            state_in   = bsrm_pkg::S_SHIFT_WR;
         end
         bsrm_pkg::S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            if (flags.shift_last) begin
               cmd.count_dec = 1'b1;
               state_in      = bsrm_pkg::S_FINISH;
            end else begin
               state_in = bsrm_pkg::S_SHIFT_RD;
            end
         end
         bsrm_pkg::S_FINISH: begin
            // Wait until the result register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = bsrm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bsrm_pkg::S_IDLE;
         end
      endcase

      // Result register occupancy.
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/bsrm_datapath.sv
// ----------------------------------------------------------------------------
// Bounded stack datapath
// Entry memory, fill count, shift pointer, command registers and the
// result registers, driven by the controller's commands.
// ----------------------------------------------------------------------------
module bsrm_datapath #(
   parameter int unsigned DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bsrm_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [bsrm_pkg::DATA_W-1:0]  req_push_value,
   input  logic [bsrm_pkg::OFFSET_W-1:0]       req_read_offset,
   input  bsrm_pkg::ctrl_cmd_type              cmd,
   output bsrm_pkg::dp_flags_type              flags,
   output logic [bsrm_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [bsrm_pkg::DATA_W-1:0]  rsp_read_data,
   output logic [bsrm_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int unsigned CW     = $clog2(DEPTH + 1);
   localparam int unsigned AW     = $clog2(DEPTH);
   localparam int unsigned XW     = (CW > bsrm_pkg::OFFSET_W) ? CW : bsrm_pkg::OFFSET_W;
   localparam int unsigned SW     = CW + 1;
   localparam int unsigned DW     = bsrm_pkg::DATA_W;
   localparam int unsigned OUT_CW = bsrm_pkg::COUNT_W;

   logic signed [DW-1:0]          entry_mem [DEPTH];
   logic signed [DW-1:0]          rd_data_ff;

   bsrm_pkg::cmd_type             cmd_ff, cmd_in;
   logic signed [DW-1:0]          value_ff, value_in;
   logic [bsrm_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 ptr_ff, ptr_in;
   bsrm_pkg::status_type          res_status_ff, res_status_in;
   logic signed [DW-1:0]          res_data_ff, res_data_in;
   logic [bsrm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic signed [DW-1:0]          rsp_data_ff, rsp_data_in;
   logic [OUT_CW-1:0]             rsp_count_ff, rsp_count_in;

   logic [CW-1:0]                 count_m1;
   logic [CW-1:0]                 mid_full;
   logic [XW-1:0]                 off_diff;
   logic [AW-1:0]                 rd_addr;
   logic [AW-1:0]                 wr_addr;
   logic signed [DW-1:0]          wr_data;
   logic                          wr_en;

   // Address arithmetic.
   assign count_m1 = count_ff - CW'(1);
   assign mid_full = count_m1 >> 1;
   assign off_diff = XW'(count_ff) - XW'(offset_ff) - XW'(1);

   // Read address select.
   always_comb begin
      case (cmd.rd_sel)
         bsrm_pkg::RD_TOP:    rd_addr = count_m1[AW-1:0];
         bsrm_pkg::RD_OFFSET: rd_addr = off_diff[AW-1:0];
         bsrm_pkg::RD_MID:    rd_addr = mid_full[AW-1:0];
         bsrm_pkg::RD_NEXT:   rd_addr = ptr_ff + AW'(1);
         default:             rd_addr = count_m1[AW-1:0];
      endcase
   end

   // One write port: a push on top, or a shift step moving an entry down.
   assign wr_en   = cmd.push_wr | cmd.shift_wr;
   assign wr_addr = cmd.shift_wr ? ptr_ff : count_ff[AW-1:0];
   assign wr_data = cmd.shift_wr ? rd_data_ff : value_ff;

   // Entry memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // Next values of the command, count, pointer and result registers.
   always_comb begin
      cmd_in        = cmd.latch_req ? bsrm_pkg::cmd_type'(req_cmd) : cmd_ff;
      value_in      = cmd.latch_req ? req_push_value : value_ff;
      offset_in     = cmd.latch_req ? req_read_offset : offset_ff;

      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_m1;
      end

      ptr_in = ptr_ff;
      if (cmd.ptr_load) begin
         ptr_in = mid_full[AW-1:0];
      end else if (cmd.shift_wr) begin
         ptr_in = ptr_ff + AW'(1);
      end

      res_status_in = cmd.res_load ? cmd.res_status : res_status_ff;
      res_data_in   = res_data_ff;
      if (cmd.res_load) begin
         res_data_in = cmd.res_from_mem ? rd_data_ff : '0;
      end

      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.rsp_load) begin
         rsp_status_in = res_status_ff;
         rsp_data_in   = res_data_ff;
         rsp_count_in  = OUT_CW'(count_ff);
      end
   end

   // The fill count is control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      offset_ff     <= offset_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Status toward the controller.
   always_comb begin
      flags.cmd        = cmd_ff;
      flags.full       = (count_ff == CW'(DEPTH));
      flags.empty      = (count_ff == '0);
      flags.one        = (count_ff == CW'(1));
      flags.offset_bad = (XW'(offset_ff) >= XW'(count_ff));
      flags.shift_last = ((SW'(ptr_ff) + SW'(2)) >= SW'(count_ff));
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// File: rtl/core/bounded_stack_remove_middle_core.sv
// ----------------------------------------------------------------------------
// Bounded stack with remove-middle
// Fixed-depth LIFO of signed 32-bit words with push, pop, remove-middle and
// read-at-offset commands, one result per command.
//
// Usage:
//   req_if carries a command (cmd, push_value, read_offset); rsp_if returns
//   its result (status, read_data, entry_count). Both are valid/ready
//   channels; a transfer takes place when valid and ready are both high.
//   One command is processed at a time. req_if.ready is high while the
//   controller is idle, also while an earlier result still waits.
//   Push and refused commands go from the S_EXEC checks straight to
//   S_FINISH; pop and read add a memory read in S_READ, and remove-middle
//   follows that read with a shift loop that alternates S_SHIFT_RD and
//   S_SHIFT_WR, moving the entries above the removed one down one place
//   at a time. A new command is taken only after the result of the last
//   one has been handed to the result register.
//   Reset empties the stack and drops any pending result. While the
//   receiver stalls, the result stays in its register and the next finished
//   command waits in the controller, with req_if.ready low.
// ----------------------------------------------------------------------------
module bounded_stack_remove_middle_core #(
   parameter int unsigned DEPTH = 8
) (
   input logic        clock,
   input logic        reset,
   bsrm_req_if.sink   req_if,
   bsrm_rsp_if.source rsp_if
);

   bsrm_pkg::ctrl_cmd_type ctrl_cmd;
   bsrm_pkg::dp_flags_type dp_flags;

   // Sequencing.
   bsrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .flags     (dp_flags),
      .cmd       (ctrl_cmd)
   );

   // Storage and result registers.
   bsrm_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_if.cmd),
      .req_push_value  (req_if.push_value),
      .req_read_offset (req_if.read_offset),
      .cmd             (ctrl_cmd),
      .flags           (dp_flags),
      .rsp_status      (rsp_if.status),
      .rsp_read_data   (rsp_if.read_data),
      .rsp_entry_count (rsp_if.entry_count)
   );

endmodule

// File: rtl/core/bsrm_checker.sv
// ----------------------------------------------------------------------------
// Bounded stack port checker
// Watches the command and result channels of the core and flags behavior
// that the design must never show.
// ----------------------------------------------------------------------------
`include "bounded_stack_remove_middle_core_assert.svh"

module bsrm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [bsrm_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [bsrm_pkg::DATA_W-1:0] rsp_read_data,
   input logic [bsrm_pkg::COUNT_W-1:0]       rsp_entry_count
);

   logic                                                       req_xfer;
   logic                                                       rsp_stall;
   logic                                                       rsp_refused;
   logic                                                       rsp_empty;
   logic                                                       rsp_zero;
   logic                                                       rsp_count_zero;
   logic [bsrm_pkg::STATUS_W+bsrm_pkg::DATA_W+bsrm_pkg::COUNT_W-1:0] rsp_word;

   // Channel conditions watched below.
   assign req_xfer       = req_valid && req_ready;
   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign rsp_refused    = rsp_valid && (rsp_status != bsrm_pkg::STATUS_OK);
   assign rsp_empty      = rsp_valid && (rsp_status == bsrm_pkg::STATUS_EMPTY);
   assign rsp_zero       = (rsp_read_data == '0);
   assign rsp_count_zero = (rsp_entry_count == '0);
   assign rsp_word       = {rsp_status, rsp_read_data, rsp_entry_count};

   // A stalled result stays offered.
   `BSRM_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_stall, rsp_valid, "result withdrawn")

   // A stalled result keeps its payload.
   `BSRM_ASSERT_NEXT(a_rsp_data, clock, reset, rsp_stall, $stable(rsp_word), "data moved")

   // Only one command is in work: no transfer in the cycle after a transfer.
   `BSRM_ASSERT_NEXT(a_one_in_work, clock, reset, req_xfer, !req_ready, "second command taken")

   // A refused command returns a zero data word.
   `BSRM_ASSERT_SAME(a_refused_zero, clock, reset, rsp_refused, rsp_zero, "refused with data")

   // An empty-stack refusal reports an empty stack.
   `BSRM_ASSERT_SAME(a_empty_count, clock, reset, rsp_empty, rsp_count_zero, "empty with entries")

endmodule

bind bounded_stack_remove_middle_core bsrm_checker u_bsrm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_status      (rsp_if.status),
   .rsp_read_data   (rsp_if.read_data),
   .rsp_entry_count (rsp_if.entry_count)
);

// File: tb/tb_bounded_stack_remove_middle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack core testbench
// Walks a table of directed stack commands covering the empty, full,
// single-entry and offset-range corner cases, then runs a long random
// command mix. Each result is checked field by field against its table
// row or a behavioral model, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bounded_stack_remove_middle_core;

   localparam int unsigned STACK_DEPTH      = 8;
   localparam int unsigned RESET_CYCLES     = 8;
   localparam int unsigned RANDOM_ITEMS     = 800;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES     = 2 * STACK_DEPTH + 8;

   typedef struct packed {
      bsrm_pkg::cmd_type                   op;
      logic signed [bsrm_pkg::DATA_W-1:0]  value;
      logic [bsrm_pkg::OFFSET_W-1:0]       offset;
   } stack_cmd_type;

   typedef struct packed {
      bsrm_pkg::status_type                status;
      logic signed [bsrm_pkg::DATA_W-1:0]  data;
      logic [bsrm_pkg::COUNT_W-1:0]        count;
   } stack_rsp_type;

   typedef struct {
      stack_cmd_type cmd;
      bit            fixed;
      stack_rsp_type rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   bsrm_req_if req_ch ();
   bsrm_rsp_if rsp_ch ();

   bounded_stack_remove_middle_core #(
      .DEPTH (STACK_DEPTH)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Behavioral copy of the stack contents.
   logic signed [bsrm_pkg::DATA_W-1:0] stack_words [STACK_DEPTH];
   int unsigned                        stack_fill;

   stack_rsp_type    stack_results_due [$];
   directed_row_type directed_rows [$];

   // Result typed into the table for the command on the channel, if any.
   bit            cur_fixed;
   stack_rsp_type cur_fixed_rsp;

   int unsigned   mismatch_count = 0;
   int unsigned   cmds_accepted  = 0;
   bit            gaps_enabled   = 1'b1;
   bit            long_hold_done = 1'b0;

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      $display("%0t ns: %s differs, expected %h, got %h", $time, what, want, got);
   endtask

   // Apply one command to the behavioral stack and return its result.
   function automatic stack_rsp_type predict_stack_result(input stack_cmd_type c);
      stack_rsp_type r;
      int unsigned   mid;
      int unsigned   i;
      r.status = bsrm_pkg::STATUS_OK;
      r.data   = '0;
      case (c.op)
         bsrm_pkg::CMD_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               r.status = bsrm_pkg::STATUS_FULL;
            end else begin
               stack_words[stack_fill] = c.value;
               stack_fill++;
            end
         end
         bsrm_pkg::CMD_POP: begin
            if (stack_fill == 0) begin
               r.status = bsrm_pkg::STATUS_EMPTY;
            end else begin
               r.data = stack_words[stack_fill-1];
               stack_words[stack_fill-1] = '0;
               stack_fill--;
            end
         end
         bsrm_pkg::CMD_REMOVE: begin
            if (stack_fill == 0) begin
               r.status = bsrm_pkg::STATUS_EMPTY;
            end else if (stack_fill == 1) begin
               r.status = bsrm_pkg::STATUS_NO_MIDDLE;
            end else begin
               mid    = (stack_fill - 1) / 2;
               r.data = stack_words[mid];
               for (i = mid; i + 1 < stack_fill; i++)
                  stack_words[i] = stack_words[i+1];
               stack_words[stack_fill-1] = '0;
               stack_fill--;
            end
         end
         default: begin
            if (stack_fill == 0)
               r.status = bsrm_pkg::STATUS_EMPTY;
            else if (c.offset >= stack_fill)
               r.status = bsrm_pkg::STATUS_RANGE;
            else
               r.data = stack_words[stack_fill-1-c.offset];
         end
      endcase
      r.count = bsrm_pkg::COUNT_W'(stack_fill);
      return r;
   endfunction

   // Gap length: mostly short, now and then long.
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Push value: extremes now and then, otherwise any word.
   function automatic logic [bsrm_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Command mix that follows the fill level, so the stack keeps moving
   // between empty and full.
   function automatic bsrm_pkg::cmd_type pick_command(input bit draining);
      int unsigned roll;
      int unsigned push_share;
      roll = $urandom_range(0, 99);
      if (stack_fill == 0)
         push_share = 70;
      else if (stack_fill >= STACK_DEPTH)
         push_share = 20;
      else
         push_share = draining ? 20 : 50;
      if (roll < push_share)
         return bsrm_pkg::CMD_PUSH;
      if (roll < push_share + (100 - push_share) * 3 / 10)
         return bsrm_pkg::CMD_POP;
      if (roll < push_share + (100 - push_share) * 6 / 10)
         return bsrm_pkg::CMD_REMOVE;
      return bsrm_pkg::CMD_READ;
   endfunction

   task automatic add_row(input bsrm_pkg::cmd_type op,
                          input logic [bsrm_pkg::DATA_W-1:0] value,
                          input logic [bsrm_pkg::OFFSET_W-1:0] offset, input bit fixed,
                          input bsrm_pkg::status_type status,
                          input logic [bsrm_pkg::DATA_W-1:0] data,
                          input logic [bsrm_pkg::COUNT_W-1:0] count);
      directed_row_type row;
      row.cmd.op     = op;
      row.cmd.value  = value;
      row.cmd.offset = offset;
      row.fixed      = fixed;
      row.rsp.status = status;
      row.rsp.data   = data;
      row.rsp.count  = count;
      directed_rows.push_back(row);
   endtask

   // Offer one command from the falling edge and hold it until the transfer.
   task automatic send_command(input stack_cmd_type c, input bit fixed,
                               input stack_rsp_type fixed_rsp, input int unsigned gap);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.cmd         = c.op;
      req_ch.push_value  = c.value;
      req_ch.read_offset = c.offset;
      cur_fixed          = fixed;
      cur_fixed_rsp      = fixed_rsp;
      req_ch.valid       = 1'b1;
      do
         @(posedge clock);
      while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Predict on each command transfer and check each result transfer.
   always @(posedge clock) begin : check_proc
      stack_cmd_type c;
      stack_rsp_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            c.op     = bsrm_pkg::cmd_type'(req_ch.cmd);
            c.value  = req_ch.push_value;
            c.offset = req_ch.read_offset;
            want     = predict_stack_result(c);
            if (cur_fixed)
               want = cur_fixed_rsp;
            stack_results_due.push_back(want);
            cmds_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (stack_results_due.size() == 0) begin
               report_mismatch("unexpected result status", '0, rsp_ch.status);
            end else begin
               want = stack_results_due.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", want.status, rsp_ch.status);
               if (rsp_ch.read_data !== want.data)
                  report_mismatch("read_data", want.data, rsp_ch.read_data);
               if (rsp_ch.entry_count !== want.count)
                  report_mismatch("entry_count", want.count, rsp_ch.entry_count);
            end
         end
      end
   end

   // Result side: random stalls, plus one long hold-off that backs up the
   // core until its command input stalls.
   initial begin
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (!long_hold_done && cmds_accepted >= 150) begin
            rsp_ch.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_done = 1'b1;
         end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat (pick_gap()) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Command side: reset, the directed table, then the random mix.
   initial begin
      stack_cmd_type c;
      stack_rsp_type none;
      int unsigned   n;
      int unsigned   gap;
      bit            draining;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = bsrm_pkg::CMD_PUSH;
      req_ch.push_value  = '0;
      req_ch.read_offset = '0;
      cur_fixed          = 1'b0;
      cur_fixed_rsp      = '0;
      none               = '0;
      draining           = 1'b0;
      stack_fill         = 0;
      foreach (stack_words[k])
         stack_words[k] = '0;

      // Refusals on an empty stack, single-entry cases, then a fill to the
      // top with extreme words and a removal from the full stack.
      add_row(bsrm_pkg::CMD_POP, 32'h0, 3'd0, 1,
              bsrm_pkg::STATUS_EMPTY, 32'h0, 4'd0);
      add_row(bsrm_pkg::CMD_REMOVE, 32'h0, 3'd0, 1,
              bsrm_pkg::STATUS_EMPTY, 32'h0, 4'd0);
      add_row(bsrm_pkg::CMD_READ, 32'h0, 3'd0, 1,
              bsrm_pkg::STATUS_EMPTY, 32'h0, 4'd0);
      add_row(bsrm_pkg::CMD_PUSH, 32'h7FFF_FFFF, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd1);
      add_row(bsrm_pkg::CMD_REMOVE, 32'h0, 3'd0, 1,
              bsrm_pkg::STATUS_NO_MIDDLE, 32'h0, 4'd1);
      add_row(bsrm_pkg::CMD_READ, 32'h0, 3'd1, 1,
              bsrm_pkg::STATUS_RANGE, 32'h0, 4'd1);
      add_row(bsrm_pkg::CMD_READ, 32'h0, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h7FFF_FFFF, 4'd1);
      add_row(bsrm_pkg::CMD_PUSH, 32'h8000_0000, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd2);
      add_row(bsrm_pkg::CMD_REMOVE, 32'h0, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h7FFF_FFFF, 4'd1);
      add_row(bsrm_pkg::CMD_POP, 32'h0, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h8000_0000, 4'd0);
      add_row(bsrm_pkg::CMD_PUSH, 32'hFFFF_FFFF, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd1);
      add_row(bsrm_pkg::CMD_PUSH, 32'h0000_0000, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd2);
      add_row(bsrm_pkg::CMD_PUSH, 32'hAAAA_AAAA, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd3);
      add_row(bsrm_pkg::CMD_PUSH, 32'h5555_5555, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd4);
      add_row(bsrm_pkg::CMD_PUSH, 32'h0000_0001, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd5);
      add_row(bsrm_pkg::CMD_PUSH, 32'hFFFF_FFFE, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd6);
      add_row(bsrm_pkg::CMD_PUSH, 32'h1234_5678, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd7);
      add_row(bsrm_pkg::CMD_PUSH, 32'hDEAD_BEEF, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd8);
      add_row(bsrm_pkg::CMD_PUSH, 32'h1357_9BDF, 3'd0, 1,
              bsrm_pkg::STATUS_FULL, 32'h0, 4'd8);
      add_row(bsrm_pkg::CMD_READ, 32'h0, 3'd7, 1,
              bsrm_pkg::STATUS_OK, 32'hFFFF_FFFF, 4'd8);
      add_row(bsrm_pkg::CMD_REMOVE, 32'h0, 3'd0, 1,
              bsrm_pkg::STATUS_OK, 32'h5555_5555, 4'd7);
      add_row(bsrm_pkg::CMD_READ, 32'h0, 3'd3, 0,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd0);
      add_row(bsrm_pkg::CMD_READ, 32'h0, 3'd6, 0,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd0);
      add_row(bsrm_pkg::CMD_REMOVE, 32'h0, 3'd0, 0,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd0);
      add_row(bsrm_pkg::CMD_POP, 32'h0, 3'd0, 0,
              bsrm_pkg::STATUS_OK, 32'h0, 4'd0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
         send_command(directed_rows[r].cmd, directed_rows[r].fixed,
                      directed_rows[r].rsp, gap);
      end

      // Random mix; idling and the fill bias change every hundred commands.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            gaps_enabled = ($urandom_range(0, 3) != 0);
            draining     = ($urandom_range(0, 2) == 0);
         end
         c.op    = pick_command(draining);
         c.value = pick_value();
         if (stack_fill != 0 && $urandom_range(0, 9) < 7)
            c.offset = bsrm_pkg::OFFSET_W'($urandom_range(0, stack_fill - 1));
         else
            c.offset = bsrm_pkg::OFFSET_W'($urandom_range(0, 7));
         gap = 0;
         if (gaps_enabled && $urandom_range(0, 9) < 4)
            gap = pick_gap();
         send_command(c, 1'b0, none, gap);
      end
      req_ch.valid = 1'b0;

      // Wait for every outstanding result, then watch for strays.
      while (stack_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bsrm_pkg.sv
rtl/core/bsrm_req_if.sv
rtl/core/bsrm_rsp_if.sv
rtl/core/bsrm_ctrl.sv
rtl/core/bsrm_datapath.sv
rtl/core/bounded_stack_remove_middle_core.sv
rtl/core/bsrm_checker.sv
tb/tb_bounded_stack_remove_middle_core.sv
